/* hw/rtl/frls_pkg.sv */
// ----------------------------------------------------------------------------
// frls_pkg
// Shared types and constants of the flash record log slot store.
// ----------------------------------------------------------------------------
`default_nettype none

package frls_pkg;

  localparam logic [15:0] ERASED       = 16'hFFFF;
  localparam int          RESULT_LIMIT = 32;
  localparam int          SLOT_CAP     = 256;

  localparam int CFG_AW = 1;
  localparam int CFG_DW = 9;

  localparam logic [CFG_AW-1:0] REG_SLOT_WORDS = 1'b0;
  localparam logic [CFG_AW-1:0] REG_SLOT_COUNT = 1'b1;

  localparam logic [5:0] SLOT_WORDS_RST = 6'd8;
  localparam logic [8:0] SLOT_COUNT_RST = 9'd32;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ERASED = 2'd1;
  localparam logic [1:0] ST_DROP   = 2'd2;
  localparam logic [1:0] ST_NONE   = 2'd3;

  typedef struct packed {
    logic [5:0] w;
    logic [8:0] n;
  } eff_t;

endpackage

`default_nettype wire

/* hw/rtl/frls_ram.sv */
// ----------------------------------------------------------------------------
// frls_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module frls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/frls_cfg.sv */
// ----------------------------------------------------------------------------
// frls_cfg
// Configuration registers and the effective slot size and slot count.
// ----------------------------------------------------------------------------
`default_nettype none

module frls_cfg #(
  parameter int STORE_WORDS    = 256,
  parameter int MAX_SLOT_WORDS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [frls_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [frls_pkg::CFG_DW-1:0] cfg_wdata,
  output      frls_pkg::eff_t              eff
);

  import frls_pkg::*;

  localparam int W1   = (MAX_SLOT_WORDS < RESULT_LIMIT) ? MAX_SLOT_WORDS : RESULT_LIMIT;
  localparam int WCAP = (W1 < STORE_WORDS) ? W1 : STORE_WORDS;
  localparam int TIW  = $clog2(RESULT_LIMIT);

  logic [5:0] slot_words_r;
  logic [8:0] slot_count_r;
  logic [8:0] fit_tbl [RESULT_LIMIT];
  logic [5:0] w_c;
  logic [8:0] n_c;
  logic [8:0] fit_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_words_r <= SLOT_WORDS_RST;
      slot_count_r <= SLOT_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SLOT_WORDS: slot_words_r <= cfg_wdata[5:0];
        REG_SLOT_COUNT: slot_count_r <= cfg_wdata[8:0];
        default:        slot_words_r <= slot_words_r;
      endcase
    end
  end

  for (genvar g = 0; g < RESULT_LIMIT; g++) begin : g_fit
    localparam int Q = STORE_WORDS / (g + 1);
    localparam int F = (Q > SLOT_CAP) ? SLOT_CAP : Q;
    assign fit_tbl[g] = 9'(F);
  end

  always_comb begin
    w_c = slot_words_r;
    if (slot_words_r == 6'd0) begin
      w_c = 6'd1;
    end else if (slot_words_r > 6'(WCAP)) begin
      w_c = 6'(WCAP);
    end
    fit_c = fit_tbl[TIW'(w_c - 6'd1)];
    n_c   = slot_count_r;
    if (slot_count_r == 9'd0) begin
      n_c = 9'd1;
    end else if (slot_count_r > 9'(SLOT_CAP)) begin
      n_c = 9'(SLOT_CAP);
    end
    if (n_c > fit_c) begin
      n_c = fit_c;
    end
  end

  assign eff.w = w_c;
  assign eff.n = n_c;

endmodule

`default_nettype wire

/* hw/rtl/frls_ctrl.sv */
// ----------------------------------------------------------------------------
// frls_ctrl
// Sequencer: clear pass, slot scans, erase sweep, word write and read-out.
// ----------------------------------------------------------------------------
`default_nettype none

module frls_ctrl #(
  parameter int STORE_WORDS = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire frls_pkg::eff_t                 eff,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  input  wire logic                           in_func,
  input  wire logic [15:0]                    in_word,
  input  wire logic                           in_eor,
  output      logic                           out_valid,
  input  wire logic                           out_tready,
  output      logic [15:0]                    out_word,
  output      logic [7:0]                     out_slot,
  output      logic [1:0]                     out_status,
  output      logic                           out_last,
  output      logic                           mem_we,
  output      logic [$clog2(STORE_WORDS)-1:0] mem_waddr,
  output      logic [15:0]                    mem_wdata,
  output      logic [$clog2(STORE_WORDS)-1:0] mem_raddr,
  input  wire logic [15:0]                    mem_rdata
);

  import frls_pkg::*;

  localparam int AW = $clog2(STORE_WORDS);
  localparam int BW = AW + 1;
  localparam int PW = 15;

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_FIND     = 9'b000000100,
    S_LAST     = 9'b000001000,
    S_ERASE    = 9'b000010000,
    S_APPEND   = 9'b000100000,
    S_RD_ISSUE = 9'b001000000,
    S_RD_WAIT  = 9'b010000000,
    S_NOTF     = 9'b100000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic          iss_on_r, iss_on_nxt;
  logic          p_valid_r, p_valid_nxt;
  logic          hit_r, hit_nxt;
  logic          record_open_r, record_open_nxt;
  logic [7:0]    write_slot_r, write_slot_nxt;
  logic [5:0]    write_offset_r, write_offset_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [15:0]   word_r, word_nxt;
  logic          eor_r, eor_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [8:0]    slot_r, slot_nxt;
  logic [5:0]    off_r, off_nxt;
  logic [BW-1:0] base_r, base_nxt;
  logic [8:0]    p_slot_r, p_slot_nxt;
  logic [BW-1:0] p_base_r, p_base_nxt;
  logic          p_first_r, p_first_nxt;
  logic          p_lastw_r, p_lastw_nxt;
  logic          clean_r, clean_nxt;
  logic [7:0]    hit_slot_r, hit_slot_nxt;
  logic [BW-1:0] hit_base_r, hit_base_nxt;
  logic [5:0]    k_r, k_nxt;
  logic [15:0]   out_word_r, out_word_nxt;
  logic [7:0]    out_slot_r, out_slot_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic          out_last_r, out_last_nxt;

  logic [5:0]    w_m1;
  logic [8:0]    n_m1;
  logic [AW-1:0] iss_addr;
  logic [AW-1:0] rd_addr;
  logic [PW-1:0] wr_prod;
  logic          wr_ok;
  logic          slot_clean;
  logic          p_end;
  logic          p_final;
  logic          out_free;
  logic          accept;
  logic          emit;

  assign w_m1       = eff.w - 6'd1;
  assign n_m1       = eff.n - 9'd1;
  assign iss_addr   = AW'(base_r + BW'(off_r));
  assign rd_addr    = AW'(hit_base_r + BW'(k_r));
  assign wr_prod    = PW'(write_slot_r) * PW'(eff.w) + PW'(write_offset_r);
  assign wr_ok      = ({1'b0, write_slot_r} < eff.n) && (write_offset_r < eff.w);
  assign slot_clean = (mem_rdata == ERASED) && (p_first_r || clean_r);
  assign p_end      = p_valid_r && p_lastw_r;
  assign p_final    = p_end && (p_slot_r == n_m1);
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    state_nxt        = state_r;
    sweep_nxt        = sweep_r;
    iss_on_nxt       = iss_on_r;
    p_valid_nxt      = p_valid_r;
    hit_nxt          = hit_r;
    record_open_nxt  = record_open_r;
    write_slot_nxt   = write_slot_r;
    write_offset_nxt = write_offset_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    word_nxt         = word_r;
    eor_nxt          = eor_r;
    status_nxt       = status_r;
    slot_nxt         = slot_r;
    off_nxt          = off_r;
    base_nxt         = base_r;
    p_slot_nxt       = p_slot_r;
    p_base_nxt       = p_base_r;
    p_first_nxt      = p_first_r;
    p_lastw_nxt      = p_lastw_r;
    clean_nxt        = clean_r;
    hit_slot_nxt     = hit_slot_r;
    hit_base_nxt     = hit_base_r;
    k_nxt            = k_r;
    out_word_nxt     = out_word_r;
    out_slot_nxt     = out_slot_r;
    out_status_nxt   = out_status_r;
    out_last_nxt     = out_last_r;
    mem_we           = 1'b0;
    mem_waddr        = sweep_r;
    mem_wdata        = ERASED;
    mem_raddr        = '0;
    emit             = 1'b0;

    // shared scan pipeline: issue one address a cycle, check one word a cycle
    if (state_r == S_FIND || state_r == S_LAST) begin
      mem_raddr   = iss_addr;
      p_valid_nxt = iss_on_r;
      if (iss_on_r) begin
        p_slot_nxt  = slot_r;
        p_base_nxt  = base_r;
        p_first_nxt = (off_r == 6'd0);
        p_lastw_nxt = (off_r == w_m1);
        if (off_r == w_m1) begin
          off_nxt  = 6'd0;
          base_nxt = base_r + BW'(eff.w);
          slot_nxt = slot_r + 9'd1;
          if (slot_r == n_m1) begin
            iss_on_nxt = 1'b0;
          end
        end else begin
          off_nxt = off_r + 6'd1;
        end
      end
      if (p_valid_r) begin
        clean_nxt = slot_clean;
      end
    end

    case (state_r)
      S_CLEAR, S_ERASE: begin
        mem_we    = 1'b1;
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == AW'(STORE_WORDS - 1)) begin
          if (state_r == S_CLEAR) begin
            state_nxt = S_IDLE;
          end else begin
            write_slot_nxt   = 8'd0;
            write_offset_nxt = 6'd0;
            record_open_nxt  = 1'b1;
            status_nxt       = ST_ERASED;
            state_nxt        = S_APPEND;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          word_nxt    = in_word;
          eor_nxt     = in_eor;
          status_nxt  = ST_OK;
          slot_nxt    = 9'd0;
          off_nxt     = 6'd0;
          base_nxt    = '0;
          iss_on_nxt  = 1'b1;
          p_valid_nxt = 1'b0;
          hit_nxt     = 1'b0;
          if (in_func) begin
            state_nxt = S_LAST;
          end else if (!record_open_r) begin
            state_nxt = S_FIND;
          end else begin
            state_nxt = S_APPEND;
          end
        end
      end
      S_FIND: begin
        if (p_end && slot_clean) begin
          write_slot_nxt   = p_slot_r[7:0];
          write_offset_nxt = 6'd0;
          record_open_nxt  = 1'b1;
          state_nxt        = S_APPEND;
        end else if (p_final) begin
          sweep_nxt = '0;
          state_nxt = S_ERASE;
        end
      end
      S_LAST: begin
        if (p_end && !slot_clean) begin
          hit_nxt      = 1'b1;
          hit_slot_nxt = p_slot_r[7:0];
          hit_base_nxt = p_base_r;
        end
        if (p_final) begin
          k_nxt = 6'd0;
          if (hit_r || !slot_clean) begin
            state_nxt = S_RD_ISSUE;
          end else begin
            state_nxt = S_NOTF;
          end
        end
      end
      S_APPEND: begin
        if (out_free) begin
          emit           = 1'b1;
          out_word_nxt   = 16'd0;
          out_slot_nxt   = write_slot_r;
          out_status_nxt = wr_ok ? status_r : ST_DROP;
          out_last_nxt   = 1'b1;
          if (wr_ok) begin
            mem_we           = 1'b1;
            mem_waddr        = wr_prod[AW-1:0];
            mem_wdata        = word_r;
            write_offset_nxt = write_offset_r + 6'd1;
          end
          record_open_nxt = record_open_r && !eor_r;
          state_nxt       = S_IDLE;
        end
      end
      S_RD_ISSUE: begin
        mem_raddr = rd_addr;
        state_nxt = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        mem_raddr = rd_addr;
        if (out_free) begin
          emit           = 1'b1;
          out_word_nxt   = mem_rdata;
          out_slot_nxt   = hit_slot_r;
          out_status_nxt = ST_OK;
          out_last_nxt   = (k_r == w_m1);
          if (k_r == w_m1) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 6'd1;
            state_nxt = S_RD_ISSUE;
          end
        end
      end
      S_NOTF: begin
        if (out_free) begin
          emit           = 1'b1;
          out_word_nxt   = 16'd0;
          out_slot_nxt   = 8'd0;
          out_status_nxt = ST_NONE;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        sweep_nxt = '0;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      sweep_r        <= '0;
      iss_on_r       <= 1'b0;
      p_valid_r      <= 1'b0;
      hit_r          <= 1'b0;
      record_open_r  <= 1'b0;
      write_slot_r   <= 8'd0;
      write_offset_r <= 6'd0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      sweep_r        <= sweep_nxt;
      iss_on_r       <= iss_on_nxt;
      p_valid_r      <= p_valid_nxt;
      hit_r          <= hit_nxt;
      record_open_r  <= record_open_nxt;
      write_slot_r   <= write_slot_nxt;
      write_offset_r <= write_offset_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r       <= word_nxt;
    eor_r        <= eor_nxt;
    status_r     <= status_nxt;
    slot_r       <= slot_nxt;
    off_r        <= off_nxt;
    base_r       <= base_nxt;
    p_slot_r     <= p_slot_nxt;
    p_base_r     <= p_base_nxt;
    p_first_r    <= p_first_nxt;
    p_lastw_r    <= p_lastw_nxt;
    clean_r      <= clean_nxt;
    hit_slot_r   <= hit_slot_nxt;
    hit_base_r   <= hit_base_nxt;
    k_r          <= k_nxt;
    out_word_r   <= out_word_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_word   = out_word_r;
  assign out_slot   = out_slot_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_tready))
    else $error("result loaded over a pending word");

  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_ERASE || state_r == S_APPEND))
    else $error("store written outside clear, erase or append");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input taken while an item is in work");

  a_open_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(record_open_r) |-> $past(state_r == S_FIND || state_r == S_ERASE))
    else $error("record opened without a slot search");

  a_off_bound: assert property (@(posedge clk) disable iff (!rst_n)
    write_offset_r <= 6'(RESULT_LIMIT))
    else $error("write offset past slot size limit");

endmodule

`default_nettype wire

/* hw/rtl/flash_record_log_slot_store.sv */
// ----------------------------------------------------------------------------
// flash_record_log_slot_store
// Record log in an erased-is-0xFFFF halfword store split into record slots.
// ----------------------------------------------------------------------------
// Append on an open record needs no scan; append opening a record scans
// up to slot_count*slot_words words (1 word/cycle, 1 RAM read port) for a
// blank slot, and sweeps the whole store with 0xFFFF when none is blank.
// Read: full scan of slot_count*slot_words words, then the highest non-blank
// slot is read out word by word, or a not-found result follows. One at a time.
// Reset: a clear pass writes 0xFFFF to all STORE_WORDS words of the store;
// in_tready stays low until it ends. Config writes are taken throughout.
`default_nettype none

module flash_record_log_slot_store #(
  parameter int STORE_WORDS    = 256,
  parameter int MAX_SLOT_WORDS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output      logic                        in_tready,
  input  wire logic [15:0]                 in_tdata,   // word_in
  input  wire logic [0:0]                  in_tuser,   // func
  input  wire logic                        in_tlast,   // end_of_record
  output      logic                        out_tvalid,
  input  wire logic                        out_tready,
  output      logic [23:0]                 out_tdata,  // word_out, slot_index
  output      logic [1:0]                  out_tuser,  // status
  output      logic                        out_tlast,  // last
  input  wire logic                        cfg_we,
  input  wire logic [frls_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [frls_pkg::CFG_DW-1:0] cfg_wdata
);

  import frls_pkg::*;

  localparam int AW = $clog2(STORE_WORDS);

  eff_t          eff;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;
  logic [15:0]   out_word;
  logic [7:0]    out_slot;

  frls_cfg #(
    .STORE_WORDS    (STORE_WORDS),
    .MAX_SLOT_WORDS (MAX_SLOT_WORDS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .eff       (eff)
  );

  frls_ram #(
    .WIDTH (16),
    .DEPTH (STORE_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  frls_ctrl #(
    .STORE_WORDS (STORE_WORDS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .eff        (eff),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser[0]),
    .in_word    (in_tdata),
    .in_eor     (in_tlast),
    .out_valid  (out_tvalid),
    .out_tready (out_tready),
    .out_word   (out_word),
    .out_slot   (out_slot),
    .out_status (out_tuser),
    .out_last   (out_tlast),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  assign out_tdata = {out_slot, out_word};

endmodule

`default_nettype wire

/* test/tb_flash_record_log_slot_store.sv */
// ----------------------------------------------------------------------------
// tb_flash_record_log_slot_store
// Self-checking bench for the flash record log slot store: a mirror of the
// slot store predicts every result word from the accepted input words, while
// both stream sides idle at random across slot geometries, bar a steady one.
// ----------------------------------------------------------------------------
module tb_flash_record_log_slot_store;
  timeunit 1ns;
  timeprecision 1ps;

  import frls_pkg::*;

  localparam bit FN_APPEND = 1'b0;
  localparam bit FN_READ   = 1'b1;

  typedef struct packed {
    logic [15:0] word;
    logic [7:0]  slot;
    logic [1:0]  status;
    logic        last;
  } log_result_t;

  class slot_log_mirror;
    localparam int unsigned DEPTH     = 256;
    localparam int unsigned MAX_SLOT  = 32;

    logic [15:0]  mem [DEPTH];
    int unsigned  wr_slot;
    int unsigned  wr_off;
    bit           open;
    logic [5:0]   sw;
    logic [8:0]   sc;
    log_result_t  due [$];
    int           faults;
    int           items;
    int           results;
    int           st_hits [4];

    function new();
      foreach (mem[i]) mem[i] = ERASED;
      wr_slot = 0;
      wr_off  = 0;
      open    = 0;
      sw      = SLOT_WORDS_RST;
      sc      = SLOT_COUNT_RST;
    endfunction

    function void set_geometry(logic [5:0] words, logic [8:0] count);
      sw = words;
      sc = count;
    endfunction

    function int unsigned slot_size();
      int unsigned w;
      w = sw;
      if (w == 0) w = 1;
      if (w > MAX_SLOT) w = MAX_SLOT;
      if (w > RESULT_LIMIT) w = RESULT_LIMIT;
      return w;
    endfunction

    function bit slot_blank(int unsigned s, int unsigned w);
      for (int unsigned k = 0; k < w; k++)
        if (mem[s * w + k] != ERASED) return 0;
      return 1;
    endfunction

    function void queue_result(logic [15:0] word, logic [7:0] slot, logic [1:0] st,
                               logic last);
      log_result_t r;
      r.word   = word;
      r.slot   = slot;
      r.status = st;
      r.last   = last;
      due.push_back(r);
    endfunction

    function void take_item(bit func, logic [15:0] word, bit eor);
      int unsigned w;
      int unsigned n;
      int unsigned s;
      logic [1:0]  st;
      w  = slot_size();
      n  = sc;
      st = ST_OK;
      if (n == 0) n = 1;
      if (n > SLOT_CAP) n = SLOT_CAP;
      if (n > DEPTH / w) n = DEPTH / w;
      items++;
      if (func == FN_READ) begin
        for (s = n; s > 0; s--) begin
          if (!slot_blank(s - 1, w)) begin
            for (int unsigned k = 0; k < w; k++)
              queue_result(mem[(s - 1) * w + k], 8'(s - 1), ST_OK, k + 1 == w);
            return;
          end
        end
        queue_result(16'h0000, 8'd0, ST_NONE, 1'b1);
        return;
      end
      if (!open) begin
        for (s = 0; s < n; s++)
          if (slot_blank(s, w)) break;
        if (s == n) begin
          foreach (mem[i]) mem[i] = ERASED;
          s  = 0;
          st = ST_ERASED;
        end
        wr_slot        = s;
        mem[s * w]     = word;
        wr_off         = 1;
        open           = 1;
      end else if (wr_slot < n && wr_off < w) begin
        mem[wr_slot * w + wr_off] = word;
        wr_off++;
      end else begin
        st = ST_DROP;
      end
      if (eor) open = 0;
      queue_result(16'h0000, 8'(wr_slot), st, 1'b1);
    endfunction

    task report(string msg);
      faults++;
      if (faults <= 30) $display("mismatch: %s", msg);
    endtask

    task take_result(logic [15:0] word, logic [7:0] slot, logic [1:0] st, logic last);
      log_result_t e;
      results++;
      if (due.size() == 0) begin
        report($sformatf("unexpected word %h slot %0d status %0d last %0b",
                         word, slot, st, last));
        return;
      end
      e = due.pop_front();
      st_hits[e.status]++;
      if (word !== e.word)
        report($sformatf("word_out %h, want %h (result %0d)", word, e.word, results));
      if (slot !== e.slot)
        report($sformatf("slot_index %0d, want %0d (result %0d)", slot, e.slot, results));
      if (st !== e.status)
        report($sformatf("status %0d, want %0d (result %0d)", st, e.status, results));
      if (last !== e.last)
        report($sformatf("last %0b, want %0b (result %0d)", last, e.last, results));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [15:0]          in_tdata;   // word_in
  logic [0:0]           in_tuser;   // func
  logic                 in_tlast;   // end_of_record
  logic                 out_tvalid;
  logic                 out_tready;
  logic [23:0]          out_tdata;  // word_out, slot_index
  logic [1:0]           out_tuser;  // status
  logic                 out_tlast;  // last
  logic                 cfg_we;
  logic [CFG_AW-1:0]    cfg_addr;
  logic [CFG_DW-1:0]    cfg_wdata;

  slot_log_mirror mirror = new();
  bit             steady;
  int             results_seen;
  int             geometries;

  flash_record_log_slot_store dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random back-pressure plus one long hold-off.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left  = 0;
    hold_done  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (!hold_done && results_seen >= 150) begin
        hold_done  = 1;
        hold_left  = 300;
        out_tready <= 1'b0;
      end else if (steady) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 38);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      mirror.take_result(out_tdata[15:0], out_tdata[23:16], out_tuser, out_tlast);
      results_seen++;
    end
  end

  task send_item(bit func, logic [15:0] word, bit eor);
    if (!steady && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= word;
    in_tlast  <= eor;
    do @(posedge clk); while (!in_tready);
    mirror.take_item(func, word, eor);
    @(negedge clk);
  endtask

  // Drop valid, drain every due word, then let the block go quiet.
  task settle();
    int spin;
    spin = 0;
    in_tvalid <= 1'b0;
    while (mirror.due.size() != 0 && spin < 200000) begin
      @(negedge clk);
      spin++;
    end
    repeat (16) @(negedge clk);
  endtask

  task set_geometry(logic [5:0] words, logic [8:0] count);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_SLOT_WORDS;
    cfg_wdata <= {3'b000, words};
    @(negedge clk);
    cfg_addr  <= REG_SLOT_COUNT;
    cfg_wdata <= count;
    @(negedge clk);
    cfg_we    <= 1'b0;
    mirror.set_geometry(words, count);
    geometries++;
  endtask

  function logic [15:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 10) return ERASED;
    if (r < 15) return 16'h0000;
    return 16'($urandom_range(16'hFFFF));
  endfunction

  task random_traffic(int count);
    int left;
    int r;
    int len;
    int w;
    left = count;
    while (left > 0) begin
      r = $urandom_range(99);
      if (r < 14) begin
        send_item(FN_READ, pick_word(), $urandom_range(1));
        left--;
      end else if (r < 22) begin
        send_item(FN_APPEND, pick_word(), $urandom_range(1));
        left--;
      end else begin
        w   = mirror.slot_size();
        len = ($urandom_range(9) == 0) ? w + $urandom_range(1, 3) : $urandom_range(1, w);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(19) == 0) begin
            send_item(FN_READ, pick_word(), $urandom_range(1));
            left--;
          end
          send_item(FN_APPEND, pick_word(), i == len - 1);
          left--;
        end
      end
    end
  endtask

  initial begin
    logic [5:0] plan_words [9];
    logic [8:0] plan_count [9];
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    steady    = 0;
    plan_words = '{6'd32, 6'd0, 6'd63, 6'd1, 6'd5, 6'd3, 6'd16,
                   6'($urandom_range(63)), 6'($urandom_range(63))};
    plan_count = '{9'd8, 9'd0, 9'd511, 9'd256, 9'd300, 9'd1, 9'd511,
                   9'($urandom_range(511)), 9'($urandom_range(511))};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default geometry: 8 words, 32 slots
    send_item(FN_READ, 16'h0000, 1'b0);
    send_item(FN_APPEND, 16'h0000, 1'b0);
    send_item(FN_APPEND, 16'hFFFF, 1'b0);
    send_item(FN_READ, 16'hFFFF, 1'b1);
    send_item(FN_APPEND, 16'h8001, 1'b0);
    send_item(FN_APPEND, 16'h7FFE, 1'b0);
    send_item(FN_APPEND, 16'h5A5A, 1'b0);
    send_item(FN_APPEND, 16'hA5A5, 1'b0);
    send_item(FN_APPEND, 16'h0001, 1'b0);
    send_item(FN_APPEND, 16'hFFFE, 1'b0);
    send_item(FN_APPEND, 16'h1111, 1'b0);
    send_item(FN_APPEND, 16'h2222, 1'b1);
    send_item(FN_APPEND, 16'hFFFF, 1'b1);
    send_item(FN_APPEND, 16'h1357, 1'b1);
    send_item(FN_READ, 16'h0000, 1'b0);
    send_item(FN_APPEND, 16'hBEEF, 1'b0);
    settle();
    // shrink the count under the open slot
    set_geometry(6'd8, 9'd2);
    send_item(FN_APPEND, 16'hCAFE, 1'b1);
    send_item(FN_READ, 16'h0000, 1'b0);
    settle();
    // one single-word slot: every new record forces an erase
    set_geometry(6'd1, 9'd1);
    send_item(FN_APPEND, 16'hAAAA, 1'b1);
    send_item(FN_APPEND, 16'h5555, 1'b1);
    send_item(FN_APPEND, 16'hFFFF, 1'b0);
    send_item(FN_READ, 16'h0000, 1'b0);
    send_item(FN_APPEND, 16'h0F0F, 1'b1);
    send_item(FN_READ, 16'h0000, 1'b0);

    foreach (plan_words[p]) begin
      settle();
      set_geometry(plan_words[p], plan_count[p]);
      steady = (p == 2);
      random_traffic(38);
    end
    steady = 0;
    settle();

    if (mirror.due.size() != 0)
      mirror.report($sformatf("%0d result words never arrived", mirror.due.size()));
    $display("covered %0d input words and %0d result words over %0d slot geometries",
             mirror.items, mirror.results, geometries);
    $display("statuses: ok %0d, erased %0d, dropped %0d, not found %0d",
             mirror.st_hits[ST_OK], mirror.st_hits[ST_ERASED], mirror.st_hits[ST_DROP],
             mirror.st_hits[ST_NONE]);
    if (mirror.faults == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
